FILE: hdl/square_matrix_power_unit_defines.svh
// Assertion macros shared by the square matrix power unit RTL.
`ifndef SQUARE_MATRIX_POWER_UNIT_DEFINES_SVH
`define SQUARE_MATRIX_POWER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SMP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("square_matrix_power_unit: check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define SMP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("square_matrix_power_unit: check failed");

`endif

FILE: hdl/smp_pkg.sv
// Shared constants and register codes for the square matrix power unit.
`default_nettype none

package smp_pkg;

  localparam int unsigned MaxStatesDef = 8;
  localparam int unsigned EntryBitsDef = 32;
  localparam int unsigned FracBits     = 24;

  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  localparam int unsigned StatesW   = 4;
  localparam int unsigned ExponentW = 16;

  typedef enum logic {
    REG_STATES_IN_USE = 1'b0,
    REG_EXPONENT      = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

FILE: hdl/smp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/square_matrix_power_unit.sv
// Square matrix power unit: loads an N x N Q8.24 matrix and emits its power.
//
// Entries arrive one item per cycle in row-major order; the item that
// completes the N*N matrix starts the computation, during which the input
// stalls. With exponent p >= 2 the unit runs up to p-1 passes; in each pass
// every multiply-accumulate steps through S_RD, S_MLO, S_MHI and S_MACC
// because one shared multiplier forms the product from two half-width
// partial products. A pass that leaves the matrix unchanged ends the
// computation early. Output then shows each result item in S_ORD and S_OSHOW
// and holds it while the output stalls; an exponent of 0 or 1 goes straight
// to output. Memories need no clearing after reset.
`default_nettype none

`include "square_matrix_power_unit_defines.svh"

module square_matrix_power_unit import smp_pkg::*; #(
  parameter int unsigned MAX_STATES = MaxStatesDef,
  parameter int unsigned ENTRY_BITS = EntryBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [PaddrW-1:0]            paddr,
  input  wire logic [PdataW-1:0]            pwdata,
  output logic      [PdataW-1:0]            prdata,
  output logic                              pready,
  // entry input
  input  wire logic                         entry_valid_i,
  output logic                              entry_stall_o,
  input  wire logic signed [ENTRY_BITS-1:0] entry_value_i,
  // result output
  output logic                              result_valid_o,
  input  wire logic                         result_stall_i,
  output logic signed [ENTRY_BITS-1:0]      result_value_o,
  output logic        [2:0]                 result_row_o,
  output logic        [2:0]                 result_col_o,
  output logic                              result_saturated_o,
  output logic                              result_last_entry_o
);

  localparam int unsigned Cells = MAX_STATES * MAX_STATES;
  localparam int unsigned AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned CW    = $clog2(Cells + 1);
  localparam int unsigned NW    = $clog2(MAX_STATES + 1);
  localparam int unsigned IW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int unsigned EB    = ENTRY_BITS;
  localparam int unsigned LoW   = EB / 2;
  localparam int unsigned HiW   = EB - LoW;
  localparam int unsigned MW    = LoW + 1;
  localparam int unsigned PW    = EB + MW;
  localparam int unsigned AccW  = 2 * EB + 4;
  localparam logic [AccW-1:0] Half = AccW'(1) << (FracBits - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_RD    = 10'b00_0000_0010,
    S_MLO   = 10'b00_0000_0100,
    S_MHI   = 10'b00_0000_1000,
    S_MACC  = 10'b00_0001_0000,
    S_ROUND = 10'b00_0010_0000,
    S_CMP   = 10'b00_0100_0000,
    S_PASS  = 10'b00_1000_0000,
    S_ORD   = 10'b01_0000_0000,
    S_OSHOW = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [StatesW-1:0]   states_q;
  logic [ExponentW-1:0] exponent_q;
  logic                 cfg_we;

  assign cfg_we = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      states_q   <= StatesW'(1);
      exponent_q <= ExponentW'(1);
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[2]))
        REG_STATES_IN_USE: states_q   <= pwdata[StatesW-1:0];
        REG_EXPONENT:      exponent_q <= pwdata[ExponentW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_STATES_IN_USE: prdata = PdataW'(states_q);
      REG_EXPONENT:      prdata = PdataW'(exponent_q);
      default:           prdata = '0;
    endcase
  end

  // matrix order
  logic [NW-1:0] n;
  logic [CW-1:0] cells;
  logic [IW-1:0] n_last;

  always_comb begin
    if (states_q == '0) begin
      n = NW'(1);
    end else if (32'(states_q) > MAX_STATES) begin
      n = NW'(MAX_STATES);
    end else begin
      n = NW'(states_q);
    end
  end

  assign cells  = CW'(n) * CW'(n);
  assign n_last = IW'(n - NW'(1));

  // sequencer registers
  logic [AW-1:0]        lc_q, lc_eff;
  logic [IW-1:0]        r_q, c_q, i_q;
  logic [ExponentW-1:0] pass_q;
  logic                 sel_q, changed_q, ovf_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [EB-1:0]   res_q;

  logic entry_acc, result_acc, load_done;

  assign entry_stall_o = (state_q != S_IDLE);
  assign entry_acc     = entry_valid_i & ~entry_stall_o;
  assign result_valid_o = (state_q == S_OSHOW);
  assign result_acc    = result_valid_o & ~result_stall_i;

  assign lc_eff    = (CW'(lc_q) >= cells) ? '0 : lc_q;
  assign load_done = (CW'(lc_eff) + CW'(1)) == cells;

  // addresses
  logic [AW-1:0] ri_addr, rc_addr, ic_addr, prev_raddr;

  assign ri_addr = AW'(AW'(r_q) * AW'(n) + AW'(i_q));
  assign rc_addr = AW'(AW'(r_q) * AW'(n) + AW'(c_q));
  assign ic_addr = AW'(AW'(i_q) * AW'(n) + AW'(c_q));

  always_comb begin
    case (state_q)
      S_ROUND, S_CMP, S_PASS, S_ORD, S_OSHOW: prev_raddr = rc_addr;
      default:                               prev_raddr = ri_addr;
    endcase
  end

  // memories
  logic [EB-1:0] orig_rdata, buf0_rdata, buf1_rdata;
  logic          buf0_we, buf1_we, cmp_we;
  logic [AW-1:0] buf_waddr;
  logic [EB-1:0] buf_wdata;

  assign cmp_we    = (state_q == S_CMP);
  assign buf0_we   = entry_acc | (cmp_we & sel_q);
  assign buf1_we   = cmp_we & ~sel_q;
  assign buf_waddr = entry_acc ? lc_eff : rc_addr;
  assign buf_wdata = entry_acc ? entry_value_i : res_q;

  smp_ram #(.WIDTH(EB), .DEPTH(Cells)) u_orig (
    .clk_i   (clk_i),
    .we_i    (entry_acc),
    .waddr_i (lc_eff),
    .wdata_i (entry_value_i),
    .raddr_i (ic_addr),
    .rdata_o (orig_rdata)
  );

  smp_ram #(.WIDTH(EB), .DEPTH(Cells)) u_buf0 (
    .clk_i   (clk_i),
    .we_i    (buf0_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (prev_raddr),
    .rdata_o (buf0_rdata)
  );

  smp_ram #(.WIDTH(EB), .DEPTH(Cells)) u_buf1 (
    .clk_i   (clk_i),
    .we_i    (buf1_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (prev_raddr),
    .rdata_o (buf1_rdata)
  );

  logic signed [EB-1:0] prev_rdata;
  assign prev_rdata = sel_q ? buf1_rdata : buf0_rdata;

  // shared multiplier: full entry times one half of the other entry
  logic signed [MW-1:0] mul_op;
  logic signed [PW-1:0] mul_out;

  always_comb begin
    if (state_q == S_MLO) begin
      mul_op = $signed({1'b0, orig_rdata[LoW-1:0]});
    end else begin
      mul_op = MW'($signed(orig_rdata[LoW +: HiW]));
    end
  end

  assign mul_out = prev_rdata * mul_op;

  // round to nearest and saturate
  logic signed [AccW-1:0] acc_rnd, acc_shr;
  logic [AccW-EB:0]       top_bits;
  logic                   fits;
  logic signed [EB-1:0]   rnd_val;

  assign acc_rnd  = acc_q + $signed(Half);
  assign acc_shr  = acc_rnd >>> FracBits;
  assign top_bits = acc_shr[AccW-1:EB-1];
  assign fits     = (&top_bits) | ~(|top_bits);

  always_comb begin
    if (fits) begin
      rnd_val = acc_shr[EB-1:0];
    end else if (acc_rnd[AccW-1]) begin
      rnd_val = {1'b1, {(EB-1){1'b0}}};
    end else begin
      rnd_val = {1'b0, {(EB-1){1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (entry_acc && load_done) begin
          state_d = (exponent_q < ExponentW'(2)) ? S_ORD : S_RD;
        end
      end
      S_RD:    state_d = S_MLO;
      S_MLO:   state_d = S_MHI;
      S_MHI:   state_d = S_MACC;
      S_MACC:  state_d = (i_q == n_last) ? S_ROUND : S_RD;
      S_ROUND: state_d = S_CMP;
      S_CMP: begin
        state_d = (c_q == n_last && r_q == n_last) ? S_PASS : S_RD;
      end
      S_PASS: begin
        state_d = (!changed_q || pass_q == exponent_q) ? S_ORD : S_RD;
      end
      S_ORD:   state_d = S_OSHOW;
      S_OSHOW: begin
        if (result_acc) begin
          state_d = result_last_entry_o ? S_IDLE : S_ORD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lc_q      <= '0;
      r_q       <= '0;
      c_q       <= '0;
      i_q       <= '0;
      pass_q    <= '0;
      sel_q     <= 1'b0;
      changed_q <= 1'b0;
      ovf_q     <= 1'b0;
      acc_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (entry_acc) begin
            if (load_done) begin
              lc_q      <= '0;
              r_q       <= '0;
              c_q       <= '0;
              i_q       <= '0;
              pass_q    <= ExponentW'(2);
              sel_q     <= 1'b0;
              changed_q <= 1'b0;
              ovf_q     <= 1'b0;
              acc_q     <= '0;
            end else begin
              lc_q <= lc_eff + AW'(1);
            end
          end
        end
        S_MHI: acc_q <= acc_q + AccW'(prod_q);
        S_MACC: begin
          acc_q <= acc_q + (AccW'(prod_q) <<< LoW);
          if (i_q != n_last) begin
            i_q <= i_q + IW'(1);
          end
        end
        S_ROUND: begin
          if (!fits) begin
            ovf_q <= 1'b1;
          end
        end
        S_CMP: begin
          if (prev_rdata != res_q) begin
            changed_q <= 1'b1;
          end
          acc_q <= '0;
          i_q   <= '0;
          if (c_q == n_last) begin
            c_q <= '0;
            r_q <= (r_q == n_last) ? '0 : r_q + IW'(1);
          end else begin
            c_q <= c_q + IW'(1);
          end
        end
        S_PASS: begin
          if (changed_q) begin
            sel_q     <= ~sel_q;
            changed_q <= 1'b0;
            pass_q    <= pass_q + ExponentW'(1);
          end
        end
        S_OSHOW: begin
          if (result_acc) begin
            if (c_q == n_last) begin
              c_q <= '0;
              r_q <= (r_q == n_last) ? '0 : r_q + IW'(1);
            end else begin
              c_q <= c_q + IW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_MLO || state_q == S_MHI) begin
      prod_q <= mul_out;
    end
    if (state_q == S_ROUND) begin
      res_q <= rnd_val;
    end
  end

  assign result_value_o      = prev_rdata;
  assign result_row_o        = 3'(r_q);
  assign result_col_o        = 3'(c_q);
  assign result_saturated_o  = ovf_q;
  assign result_last_entry_o = (r_q == n_last) && (c_q == n_last);

  `SMP_ASSERT_IMP(a_out_blocks_in, result_valid_o, entry_stall_o)
  `SMP_ASSERT_NXT(a_last_ends_out, result_acc && result_last_entry_o, !result_valid_o)
  `SMP_ASSERT_NXT(a_steady_exit, state_q == S_PASS && !changed_q, state_q == S_ORD)
  `SMP_ASSERT_IMP(a_acc_cleared, state_q == S_RD && i_q == '0, acc_q == '0)

endmodule

`default_nettype wire
